### rtl/core/sgc_pkg.sv
// Shared types and constants for the copy segment generator.
package sgc_pkg;

   // Command codes carried on req_tuser.
   localparam int unsigned CMD_W = 2;
   localparam logic [CMD_W-1:0] CMD_LOAD_SRC = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_DST = 2'd1;
   localparam logic [CMD_W-1:0] CMD_START    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd3;

   // Fixed field widths.
   localparam int unsigned EADDR_W = 32;
   localparam int unsigned LEN_W   = 16;
   localparam int unsigned BYTES_W = 20;
   localparam int unsigned OADDR_W = 32;

   // Packed stream widths, padded to whole bytes.
   localparam int unsigned REQ_DATA_W = 88;
   localparam int unsigned RSP_DATA_W = 104;
   localparam int unsigned RSP_PAD_W  = RSP_DATA_W - 2 * OADDR_W - LEN_W - BYTES_W;

   // At most this many segments come out of one copy request.
   localparam int unsigned RESULT_CAP = 32;
   localparam int unsigned NSEG_W     = 6;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_src;
      logic load_dst;
      logic clear;
      logic start;
      logic skip_step;
      logic walk_init;
      logic walk_step;
      logic emit;
      logic emit_empty;
   } sgc_ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic count_zero;
      logic src_done;
      logic skip_more;
      logic walk_stop;
      logic none;
      logic last;
   } sgc_status_type;

endpackage

### rtl/core/sgc_datapath.sv
// Descriptor tables, walk registers and the result word register.
module sgc_datapath #(
   parameter int MAX_ENTRIES = 16,
   parameter int ADDR_WIDTH  = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [sgc_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  sgc_pkg::sgc_ctl_type               ctl,
   output sgc_pkg::sgc_status_type            st,
   output logic [sgc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast
);
   import sgc_pkg::*;

   localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW  = $clog2(MAX_ENTRIES + 1);
   localparam int AW  = ADDR_WIDTH;
   localparam int AWX = ADDR_WIDTH + OADDR_W;

   // Request word fields.
   logic [EADDR_W-1:0] entry_addr;
   logic [LEN_W-1:0]   entry_len;
   logic [BYTES_W-1:0] copy_offset;
   logic [BYTES_W-1:0] copy_count;

   assign entry_addr  = req_tdata[31:0];
   assign entry_len   = req_tdata[47:32];
   assign copy_offset = req_tdata[67:48];
   assign copy_count  = req_tdata[87:68];

   // Descriptor memories.
   logic [AW-1:0]    src_addr_mem [MAX_ENTRIES];
   logic [LEN_W-1:0] src_len_mem  [MAX_ENTRIES];
   logic [AW-1:0]    dst_addr_mem [MAX_ENTRIES];
   logic [LEN_W-1:0] dst_len_mem  [MAX_ENTRIES];

   logic [AW-1:0]    src_addr_rd_ff;
   logic [LEN_W-1:0] src_len_rd_ff;
   logic [AW-1:0]    dst_addr_rd_ff;
   logic [LEN_W-1:0] dst_len_rd_ff;

   logic [CW-1:0]      src_cnt_ff;
   logic [CW-1:0]      dst_cnt_ff;
   logic [CW-1:0]      si_ff;
   logic [CW-1:0]      di_ff;
   logic [BYTES_W-1:0] offset_ff;
   logic [BYTES_W-1:0] skipped_ff;
   logic [BYTES_W-1:0] remaining_ff;
   logic [BYTES_W-1:0] total_ff;
   logic [LEN_W-1:0]   os_ff;
   logic [LEN_W-1:0]   od_ff;
   logic [NSEG_W-1:0]  nseg_ff;

   logic [OADDR_W-1:0] out_sa_ff;
   logic [OADDR_W-1:0] out_da_ff;
   logic [LEN_W-1:0]   out_len_ff;
   logic [BYTES_W-1:0] out_total_ff;
   logic               out_last_ff;

   logic               src_full;
   logic               dst_full;
   logic [BYTES_W:0]   skip_sum;
   logic [BYTES_W-1:0] os_start;
   logic [LEN_W-1:0]   rs;
   logic [LEN_W-1:0]   rd;
   logic [LEN_W-1:0]   rmin;
   logic [LEN_W-1:0]   seg;
   logic [AW-1:0]      sa_sum;
   logic [AW-1:0]      da_sum;
   logic [AWX-1:0]     sa_wide;
   logic [AWX-1:0]     da_wide;

   assign src_full = (src_cnt_ff == CW'(MAX_ENTRIES));
   assign dst_full = (dst_cnt_ff == CW'(MAX_ENTRIES));

   // Skip test: does the whole current source entry lie before the offset?
   assign skip_sum = {1'b0, skipped_ff} + (BYTES_W + 1)'(src_len_rd_ff);
   assign os_start = offset_ff - skipped_ff;

   // One walk step: the segment is the least of the three remainders.
   assign rs   = src_len_rd_ff - os_ff;
   assign rd   = dst_len_rd_ff - od_ff;
   assign rmin = (rs < rd) ? rs : rd;
   assign seg  = (remaining_ff < BYTES_W'(rmin)) ? remaining_ff[LEN_W-1:0] : rmin;

   assign sa_sum  = src_addr_rd_ff + AW'(os_ff);
   assign da_sum  = dst_addr_rd_ff + AW'(od_ff);
   assign sa_wide = AWX'(sa_sum);
   assign da_wide = AWX'(da_sum);

   always_comb begin
      st            = '0;
      st.count_zero = (copy_count == '0);
      st.src_done   = (si_ff >= src_cnt_ff);
      st.skip_more  = (skip_sum <= {1'b0, offset_ff});
      st.walk_stop  = (remaining_ff == '0) || (si_ff >= src_cnt_ff) ||
                      (di_ff >= dst_cnt_ff) || (nseg_ff == NSEG_W'(RESULT_CAP)) ||
                      (src_len_rd_ff == '0) || (dst_len_rd_ff == '0);
      st.none       = (nseg_ff == '0);
      st.last       = out_last_ff;
   end

   // Memory write and registered read.
   always_ff @(posedge clock) begin
      if (ctl.load_src && !src_full) begin
         src_addr_mem[src_cnt_ff[IW-1:0]] <= AW'(entry_addr);
         src_len_mem[src_cnt_ff[IW-1:0]]  <= entry_len;
      end
      if (ctl.load_dst && !dst_full) begin
         dst_addr_mem[dst_cnt_ff[IW-1:0]] <= AW'(entry_addr);
         dst_len_mem[dst_cnt_ff[IW-1:0]]  <= entry_len;
      end
      src_addr_rd_ff <= src_addr_mem[si_ff[IW-1:0]];
      src_len_rd_ff  <= src_len_mem[si_ff[IW-1:0]];
      dst_addr_rd_ff <= dst_addr_mem[di_ff[IW-1:0]];
      dst_len_rd_ff  <= dst_len_mem[di_ff[IW-1:0]];
   end

   // Entry counts.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_cnt_ff <= '0;
         dst_cnt_ff <= '0;
      end else if (ctl.clear) begin
         src_cnt_ff <= '0;
         dst_cnt_ff <= '0;
      end else begin
         if (ctl.load_src && !src_full) begin
            src_cnt_ff <= src_cnt_ff + 1'b1;
         end
         if (ctl.load_dst && !dst_full) begin
            dst_cnt_ff <= dst_cnt_ff + 1'b1;
         end
      end
   end

   // Walk position and byte counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         si_ff   <= '0;
         di_ff   <= '0;
         nseg_ff <= '0;
      end else if (ctl.start) begin
         si_ff        <= '0;
         di_ff        <= '0;
         nseg_ff      <= '0;
         skipped_ff   <= '0;
         offset_ff    <= copy_offset;
         remaining_ff <= copy_count;
         total_ff     <= '0;
         os_ff        <= '0;
         od_ff        <= '0;
      end else if (ctl.skip_step) begin
         skipped_ff <= skip_sum[BYTES_W-1:0];
         si_ff      <= si_ff + 1'b1;
      end else if (ctl.walk_init) begin
         os_ff <= os_start[LEN_W-1:0];
      end else if (ctl.walk_step) begin
         total_ff     <= total_ff + BYTES_W'(seg);
         remaining_ff <= remaining_ff - BYTES_W'(seg);
         nseg_ff      <= nseg_ff + 1'b1;
         if (rs < rd) begin
            si_ff <= si_ff + 1'b1;
            os_ff <= '0;
            od_ff <= od_ff + seg;
         end else if (rs > rd) begin
            di_ff <= di_ff + 1'b1;
            od_ff <= '0;
            os_ff <= os_ff + seg;
         end else begin
            si_ff <= si_ff + 1'b1;
            di_ff <= di_ff + 1'b1;
            os_ff <= '0;
            od_ff <= '0;
         end
      end
   end

   // Result word. The segment is written during the step; last is settled
   // once the next entries have been fetched and the stop test is known.
   always_ff @(posedge clock) begin
      if (ctl.emit_empty) begin
         out_sa_ff    <= '0;
         out_da_ff    <= '0;
         out_len_ff   <= '0;
         out_total_ff <= '0;
         out_last_ff  <= 1'b1;
      end else if (ctl.walk_step) begin
         out_sa_ff    <= sa_wide[OADDR_W-1:0];
         out_da_ff    <= da_wide[OADDR_W-1:0];
         out_len_ff   <= seg;
         out_total_ff <= total_ff + BYTES_W'(seg);
      end else if (ctl.emit) begin
         out_last_ff <= st.walk_stop;
      end
   end

   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, out_total_ff, out_len_ff, out_da_ff, out_sa_ff};
   assign rsp_tlast = out_last_ff;

`ifndef SYNTHESIS
   a_seg_nonzero: assert property (@(posedge clock) disable iff (reset)
      ctl.walk_step |-> (seg != '0))
      else $error("walk step produced an empty segment");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (src_cnt_ff <= CW'(MAX_ENTRIES)) && (dst_cnt_ff <= CW'(MAX_ENTRIES)))
      else $error("descriptor count beyond table depth");

   a_seg_cap: assert property (@(posedge clock) disable iff (reset)
      ctl.walk_step |-> (nseg_ff < NSEG_W'(RESULT_CAP)))
      else $error("walk step beyond the segment cap");
`endif

endmodule

### rtl/core/sgc_ctrl.sv
// Controller state machine for the copy segment generator.
module sgc_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sgc_pkg::CMD_W-1:0]     req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  sgc_pkg::sgc_status_type       st,
   output sgc_pkg::sgc_ctl_type          ctl
);
   import sgc_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SFETCH = 3'd1;
   localparam logic [2:0] S_SKIP   = 3'd2;
   localparam logic [2:0] S_CHECK  = 3'd3;
   localparam logic [2:0] S_WALK   = 3'd4;
   localparam logic [2:0] S_WFETCH = 3'd5;
   localparam logic [2:0] S_OUT    = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      req_tready = (state_ff == S_IDLE);
      rsp_tvalid = (state_ff == S_OUT);
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               case (req_tuser)
                  CMD_LOAD_SRC: ctl.load_src = 1'b1;
                  CMD_LOAD_DST: ctl.load_dst = 1'b1;
                  CMD_CLEAR:    ctl.clear = 1'b1;
                  CMD_START: begin
                     ctl.start = 1'b1;
                     if (st.count_zero) begin
                        ctl.emit_empty = 1'b1;
                        state_in       = S_OUT;
                     end else begin
                        state_in = S_SFETCH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_SFETCH: state_in = S_SKIP;
         S_SKIP: begin
            if (st.src_done) begin
               ctl.emit_empty = 1'b1;
               state_in       = S_OUT;
            end else if (st.skip_more) begin
               ctl.skip_step = 1'b1;
               state_in      = S_SFETCH;
            end else begin
               ctl.walk_init = 1'b1;
               state_in      = S_CHECK;
            end
         end
         S_CHECK: begin
            if (st.none) begin
               if (st.walk_stop) begin
                  ctl.emit_empty = 1'b1;
                  state_in       = S_OUT;
               end else begin
                  state_in = S_WALK;
               end
            end else begin
               ctl.emit = 1'b1;
               state_in = S_OUT;
            end
         end
         S_WALK: begin
            ctl.walk_step = 1'b1;
            state_in      = S_WFETCH;
         end
         S_WFETCH: state_in = S_CHECK;
         S_OUT: begin
            if (rsp_tready) begin
               state_in = st.last ? S_IDLE : S_WALK;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_sides_apart: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result word is pending");

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.load_src, ctl.load_dst, ctl.clear, ctl.start,
                ctl.skip_step, ctl.walk_init, ctl.walk_step, ctl.emit}))
      else $error("more than one datapath action in a cycle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result word withdrawn before it was taken");
`endif

endmodule

### rtl/core/scatter_gather_copy_segmenter.sv
// A load or clear word is done as soon as it is taken. A start word first skips the source
// entries that lie wholly before the offset, then walks both tables, one result word per segment.
// An empty result comes after a zero-count start, after an offset past the source list, and
// when the walk finds no segment.
// One word at a time: no input word is taken until the last result word of a start is taken.
// Reset is synchronous and active high; it empties both tables but leaves their contents.
module scatter_gather_copy_segmenter #(
   parameter int MAX_ENTRIES = 16,
   parameter int ADDR_WIDTH  = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // Input words.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // entry_addr[31:0], entry_len[47:32], copy_offset[67:48], copy_count[87:68]
   input  logic [sgc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // cmd[1:0]
   input  logic [sgc_pkg::CMD_W-1:0]         req_tuser,
   // Result words, one per copy segment, or one all-zero word when nothing is copied.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // seg_src_addr[31:0], seg_dst_addr[63:32], seg_len[79:64],
   // total_copied[99:80], zero padding[103:100]
   output logic [sgc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // last: marks the final word of a copy request
   output logic                              rsp_tlast
);
   import sgc_pkg::*;

   // The controller sequences loads, the skip over leading source entries and
   // the joint walk of both tables. The datapath owns the tables, the walk
   // counters and the result word register; the two talk only through the
   // command and status structs below.
   sgc_ctl_type    ctl;
   sgc_status_type st;

   sgc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .st         (st),
      .ctl        (ctl)
   );

   // Each segment is written into the result register during its walk step.
   // Its last flag is settled only after the next table entries have been
   // read, since the stop test depends on them.
   sgc_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .ADDR_WIDTH  (ADDR_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .ctl       (ctl),
      .st        (st),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

### tb/scatter_gather_copy_segmenter_tb.sv
// Self-checking testbench for the copy segment generator: directed and random descriptor walks.
`timescale 1ns / 100ps

module scatter_gather_copy_segmenter_tb;
   import sgc_pkg::*;

   localparam int TABLE_DEPTH   = 16;
   localparam int ITEM_TARGET   = 210;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 20;

   // One expected copy segment, as it should appear on the result stream.
   typedef struct {
      logic [OADDR_W-1:0] src_addr;
      logic [OADDR_W-1:0] dst_addr;
      logic [LEN_W-1:0]   seg_len;
      logic [BYTES_W-1:0] total;
      logic               last;
   } copy_seg_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]      req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // Shadow copy of the descriptor tables, kept in step with the accepted words.
   logic [EADDR_W-1:0] src_base [TABLE_DEPTH];
   logic [LEN_W-1:0]   src_size [TABLE_DEPTH];
   logic [EADDR_W-1:0] dst_base [TABLE_DEPTH];
   logic [LEN_W-1:0]   dst_size [TABLE_DEPTH];
   int unsigned        src_count = 0;
   int unsigned        dst_count = 0;

   copy_seg_type pending_segs[$];
   int unsigned  errors       = 0;
   int unsigned  items_sent   = 0;
   int unsigned  cycle_count  = 0;
   int unsigned  stall_left   = 0;
   bit           idle_enabled = 1'b1;

   scatter_gather_copy_segmenter #(
      .MAX_ENTRIES(TABLE_DEPTH),
      .ADDR_WIDTH (32)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Applies one accepted word to the shadow tables. A start word expands into the
   // segments it must produce. Returns 0 for a load that a full table drops.
   function automatic bit predict_word(input logic [CMD_W-1:0] cmd,
                                       input logic [EADDR_W-1:0] addr,
                                       input logic [LEN_W-1:0] len,
                                       input logic [BYTES_W-1:0] offset,
                                       input logic [BYTES_W-1:0] count);
      int unsigned  si, di, skipped, os, od, remaining, total, rs, rd, chunk, nseg;
      copy_seg_type seg;
      if (cmd == CMD_LOAD_SRC) begin
         if (src_count >= TABLE_DEPTH) return 1'b0;
         src_base[src_count] = addr;
         src_size[src_count] = len;
         src_count++;
         return 1'b1;
      end
      if (cmd == CMD_LOAD_DST) begin
         if (dst_count >= TABLE_DEPTH) return 1'b0;
         dst_base[dst_count] = addr;
         dst_size[dst_count] = len;
         dst_count++;
         return 1'b1;
      end
      if (cmd == CMD_CLEAR) begin
         src_count = 0;
         dst_count = 0;
         return 1'b1;
      end

      nseg = 0;
      if (count != 0) begin
         // Whole source entries that end at or before the offset are passed over,
         // zero-length ones included.
         si      = 0;
         skipped = 0;
         while (si < src_count && skipped + src_size[si] <= offset) begin
            skipped += src_size[si];
            si++;
         end
         if (si < src_count) begin
            os        = offset - skipped;
            od        = 0;
            di        = 0;
            remaining = count;
            total     = 0;
            while (remaining > 0 && si < src_count && di < dst_count && nseg < RESULT_CAP) begin
               if (src_size[si] == 0 || dst_size[di] == 0) break;
               rs    = src_size[si] - os;
               rd    = dst_size[di] - od;
               chunk = remaining;
               if (rs < chunk) chunk = rs;
               if (rd < chunk) chunk = rd;
               total     += chunk;
               remaining -= chunk;
               // Addresses wrap at 32 bits.
               seg.src_addr = src_base[si] + os;
               seg.dst_addr = dst_base[di] + od;
               seg.seg_len  = LEN_W'(chunk);
               seg.total    = BYTES_W'(total);
               seg.last     = 1'b0;
               pending_segs.push_back(seg);
               nseg++;
               if (rs < rd) begin
                  si++;
                  os = 0;
                  od += chunk;
               end else if (rs > rd) begin
                  di++;
                  od = 0;
                  os += chunk;
               end else begin
                  si++;
                  di++;
                  os = 0;
                  od = 0;
               end
            end
         end
      end

      if (nseg == 0) begin
         // Nothing copied: one all-zero word that closes the request.
         seg.src_addr = '0;
         seg.dst_addr = '0;
         seg.seg_len  = '0;
         seg.total    = '0;
         seg.last     = 1'b1;
         pending_segs.push_back(seg);
      end else begin
         pending_segs[pending_segs.size()-1].last = 1'b1;
      end
      return 1'b1;
   endfunction

   // Drives one input word and holds it until the block takes it. Valid is left high
   // after the handshake so that back-to-back words need no extra edge.
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [EADDR_W-1:0] addr,
                            input logic [LEN_W-1:0] len, input logic [BYTES_W-1:0] offset,
                            input logic [BYTES_W-1:0] count);
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {count, offset, len, addr};
      do @(posedge clock); while (!req_tready);
      if (predict_word(cmd, addr, len, offset, count)) items_sent++;
   endtask

   task automatic load_entry(input logic [CMD_W-1:0] cmd, input logic [EADDR_W-1:0] addr,
                             input logic [LEN_W-1:0] len);
      send_word(cmd, addr, len, BYTES_W'($urandom), BYTES_W'($urandom));
   endtask

   task automatic start_copy(input logic [BYTES_W-1:0] offset, input logic [BYTES_W-1:0] count);
      send_word(CMD_START, $urandom, LEN_W'($urandom), offset, count);
   endtask

   task automatic clear_tables();
      send_word(CMD_CLEAR, $urandom, LEN_W'($urandom), BYTES_W'($urandom),
                BYTES_W'($urandom));
   endtask

   // Lowers valid and holds off until every outstanding segment has been seen.
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_segs.size() != 0) @(posedge clock);
   endtask

   // Entry lengths lean small so walks produce many segments, with the extremes mixed in.
   function automatic logic [LEN_W-1:0] pick_len();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return LEN_W'($urandom);
         default: return LEN_W'($urandom_range(1, 48));
      endcase
   endfunction

   // Starts on empty tables must each give the single empty word.
   task automatic test_empty_tables();
      idle_enabled = 1'b1;
      start_copy(20'd0, 20'd0);
      start_copy('1, '1);
      clear_tables();
   endtask

   // Field extremes: addresses that wrap, a full-length source entry, an offset
   // landing exactly on an entry boundary, and an offset past the whole list.
   task automatic test_address_extremes();
      clear_tables();
      load_entry(CMD_LOAD_SRC, 32'hFFFF_FFF0, 16'hFFFF);
      load_entry(CMD_LOAD_SRC, 32'h0000_1000, 16'd100);
      load_entry(CMD_LOAD_DST, 32'hFFFF_FF00, 16'd300);
      load_entry(CMD_LOAD_DST, 32'h0000_0000, 16'hFFFF);
      start_copy(20'd5, 20'hFFFFF);
      start_copy(20'd65535, 20'd50);
      start_copy(20'd65635, 20'd10);
      start_copy(20'd0, 20'd0);
   endtask

   // Zero-length entries: skipped when they lie before the offset, and a walk stop
   // when the walk reaches one in either table.
   task automatic test_zero_length_entries();
      clear_tables();
      load_entry(CMD_LOAD_SRC, 32'h1000_0000, 16'd0);
      load_entry(CMD_LOAD_SRC, 32'h2000_0000, 16'd50);
      load_entry(CMD_LOAD_SRC, 32'h3000_0000, 16'd0);
      load_entry(CMD_LOAD_DST, 32'h4000_0000, 16'd40);
      load_entry(CMD_LOAD_DST, 32'h5000_0000, 16'd0);
      start_copy(20'd0, 20'd100);
      start_copy(20'd10, 20'd100);
      start_copy(20'd0, 20'd7);
      // Let the sender sit idle until the block has answered everything.
      wait_for_results();
   endtask

   // Random table builds followed by copies, with stray words of any kind thrown in.
   task automatic test_random_copies();
      int unsigned seq, nsrc, ndst, nstart, nnoise, src_total, limit, k;
      logic [BYTES_W-1:0] offset, count;
      seq = 0;
      while (items_sent < ITEM_TARGET - 12) begin
         idle_enabled = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 3) != 0) clear_tables();
         if (seq == 1) begin
            // Overfill both tables once so that dropped loads are exercised.
            nsrc = TABLE_DEPTH + 1;
            ndst = TABLE_DEPTH + 1;
         end else begin
            nsrc = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 18) : $urandom_range(1, 6);
            ndst = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 18) : $urandom_range(1, 6);
         end
         for (k = 0; k < nsrc; k++) load_entry(CMD_LOAD_SRC, $urandom, pick_len());
         for (k = 0; k < ndst; k++) load_entry(CMD_LOAD_DST, $urandom, pick_len());

         src_total = 0;
         for (k = 0; k < src_count; k++) src_total += src_size[k];
         limit = (src_total > 20'hFFFFF) ? 20'hFFFFF : src_total;

         nstart = $urandom_range(1, 3);
         for (k = 0; k < nstart; k++) begin
            case ($urandom_range(0, 5))
               0:       offset = '0;
               4:       offset = BYTES_W'($urandom);
               5:       offset = BYTES_W'(limit);
               default: offset = BYTES_W'($urandom_range(0, limit));
            endcase
            case ($urandom_range(0, 5))
               0:       count = '0;
               4:       count = BYTES_W'($urandom);
               5:       count = '1;
               default: count = BYTES_W'($urandom_range(1, limit + 1));
            endcase
            start_copy(offset, count);
         end

         if ($urandom_range(0, 4) == 0) begin
            nnoise = $urandom_range(1, 3);
            for (k = 0; k < nnoise; k++) begin
               send_word(CMD_W'($urandom_range(0, 3)), $urandom, LEN_W'($urandom),
                         BYTES_W'($urandom), BYTES_W'($urandom));
            end
         end
         if (seq == 3) wait_for_results();
         seq++;
      end
   endtask

   // Closing stretch with both sides running flat out.
   task automatic test_steady_stream();
      int unsigned k;
      idle_enabled = 1'b0;
      clear_tables();
      for (k = 0; k < 3; k++) begin
         load_entry(CMD_LOAD_SRC, $urandom, LEN_W'($urandom_range(1, 40)));
      end
      for (k = 0; k < 3; k++) begin
         load_entry(CMD_LOAD_DST, $urandom, LEN_W'($urandom_range(1, 40)));
      end
      start_copy(20'd0, 20'hFFFFF);
      start_copy(BYTES_W'($urandom_range(0, 30)), BYTES_W'($urandom_range(1, 60)));
      start_copy(20'd3, 20'd1);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_tables();
      test_address_extremes();
      test_zero_length_entries();
      test_random_copies();
      test_steady_stream();
      wait_for_results();
      // Loads finish once they are taken; this covers any word still in flight.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Receiver back-pressure: random stalls while enabled.
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         errors++;
      end
   endtask

   // Every accepted result word is matched against the oldest expected segment.
   always @(posedge clock) begin
      copy_seg_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_segs.size() == 0) begin
            $display("%0t: result word with none expected, expected nothing, actual %h last %b",
                     $time, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            want = pending_segs.pop_front();
            check_field("seg_src_addr", want.src_addr, rsp_tdata[31:0]);
            check_field("seg_dst_addr", want.dst_addr, rsp_tdata[63:32]);
            check_field("seg_len", 32'(want.seg_len), 32'(rsp_tdata[79:64]));
            check_field("total_copied", 32'(want.total), 32'(rsp_tdata[99:80]));
            check_field("last", 32'(want.last), 32'(rsp_tlast));
         end
      end
   end

   // Watchdog: a hang anywhere ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d segments outstanding",
                  cycle_count, pending_segs.size());
         $display("Some tests failed");
         $finish;
      end
   end

endmodule
